/* rtl/complementary_tilt_filter_macros.svh */
// assertion helpers used by the queue
`ifndef COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define COMPLEMENTARY_TILT_FILTER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define CTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ctf_pkg.sv */
package ctf_pkg;

    // angle format and widths
    localparam int ANG_W   = 32;
    localparam int SMP_W   = 16;
    localparam int COEF_W  = 16;
    localparam int SCALE_W = 32;
    localparam int AR_W    = 49;   // coefficient times raw tilt
    localparam int CX_W    = 36;   // cordic x and y datapath
    localparam int ACC_W   = 52;   // filter accumulate width before saturation
    localparam int ATAN_N  = 28;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;

    // rounded atan(2^-i) in q4.28
    localparam logic signed [ANG_W-1:0] ATAN_Q28 [0:ATAN_N-1] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32,
        32'sd16,        32'sd8,         32'sd4,        32'sd2
    };

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_COEF = 1'b0,
        REG_GYRO_SCALE  = 1'b1
    } t_cfg_reg;

    // one imu sample
    typedef struct packed {
        logic signed [SMP_W-1:0] accel_y;
        logic signed [SMP_W-1:0] accel_z;
        logic signed [SMP_W-1:0] gyro_rate;
    } t_smp;

    // one result
    typedef struct packed {
        logic signed [ANG_W-1:0] raw_tilt;
        logic signed [ANG_W-1:0] integrated_angle;
        logic signed [ANG_W-1:0] low_passed;
        logic signed [ANG_W-1:0] high_passed;
        logic signed [ANG_W-1:0] fused_angle;
    } t_res;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [ANG_W-1:0] raw_tilt;
        logic signed [AR_W-1:0]  coef_raw;
        logic        [ANG_W-1:0] inc;
    } t_fq_item;

    // queue status seen by the back end
    typedef struct packed {
        logic     valid;
        t_fq_item item;
    } t_q_head;

    // clamp a wide signed value to the 32 bit angle range
    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = ACC_W'(-33'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[ANG_W-1:0];
    endfunction

endpackage

/* rtl/ctf_in_if.sv */
interface ctf_in_if;
    logic          valid;
    logic          ready;
    ctf_pkg::t_smp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ctf_out_if.sv */
interface ctf_out_if;
    logic          valid;
    logic          ready;
    ctf_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ctf_front.sv */
module ctf_front #(
    parameter int STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  ctf_pkg::t_smp                     i_smp,
    input  logic [ctf_pkg::COEF_W-1:0]        i_coef,
    input  logic [ctf_pkg::SCALE_W-1:0]       i_scale,
    output logic                              o_push,
    output ctf_pkg::t_fq_item                 o_item
);

    localparam int XW = ctf_pkg::CX_W;
    localparam int AW = ctf_pkg::ANG_W;
    localparam int PW = ctf_pkg::AR_W;

    // stage payloads, index 0 after pre-rotation, index i+1 after step i
    logic signed [XW-1:0] r_x    [0:STEPS];
    logic signed [XW-1:0] r_y    [0:STEPS];
    logic signed [AW-1:0] r_z    [0:STEPS];
    logic        [AW-1:0] r_inc  [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic [STEPS:0]       r_vld;

    logic                 r_f_vld;
    ctf_pkg::t_fq_item    r_f_item;

    // pre-rotation into the right half plane
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;
    logic signed [AW-1:0] n_z0;
    logic signed [PW-1:0] gprod;

    always_comb begin
        xs = XW'(i_smp.accel_y) <<< 16;
        ys = (-XW'(i_smp.accel_z)) <<< 16;
        n_x0 = xs;
        n_y0 = ys;
        n_z0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_x0 = ys;
                n_y0 = -xs;
                n_z0 = ctf_pkg::HALF_PI_Q28;
            end else begin
                n_x0 = -ys;
                n_y0 = xs;
                n_z0 = -ctf_pkg::HALF_PI_Q28;
            end
        end
        gprod = PW'(i_smp.gyro_rate) * $signed({{(PW-ctf_pkg::SCALE_W){1'b0}}, i_scale});
    end

    // valid shift line, the pipeline never stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_f_vld <= 1'b0;
        end else begin
            r_vld   <= {r_vld[STEPS-1:0], i_take};
            r_f_vld <= r_vld[STEPS];
        end
    end

    // stage zero payload
    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_inc[0]  <= gprod[47:16];
        r_zero[0] <= (i_smp.accel_y == '0) && (i_smp.accel_z == '0);
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + ctf_pkg::ATAN_Q28[i];
            end else begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - ctf_pkg::ATAN_Q28[i];
            end
            r_inc[i+1]  <= r_inc[i];
            r_zero[i+1] <= r_zero[i];
        end
    end

    // final stage: zero-vector case and coefficient product for the low-pass
    logic signed [AW-1:0] raw;
    logic signed [PW-1:0] ar;
    assign raw = r_zero[STEPS] ? '0 : r_z[STEPS];
    assign ar  = PW'(raw) * $signed({{(PW-ctf_pkg::COEF_W){1'b0}}, i_coef});

    always_ff @(posedge i_clk) begin
        r_f_item.raw_tilt <= raw;
        r_f_item.coef_raw <= ar;
        r_f_item.inc      <= r_inc[STEPS];
    end

    assign o_push = r_f_vld;
    assign o_item = r_f_item;

endmodule

/* rtl/ctf_queue.sv */
`include "complementary_tilt_filter_macros.svh"

module ctf_queue #(
    parameter int AW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_reserve,
    input  logic              i_push,
    input  ctf_pkg::t_fq_item i_item,
    input  logic              i_pop,
    output ctf_pkg::t_q_head  o_head,
    output logic              o_room
);

    localparam int unsigned QD = 2 ** AW;
    localparam logic [AW:0] FULL_CNT = (AW+1)'(QD);

    ctf_pkg::t_fq_item r_mem [0:QD-1];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_fill;
    logic [AW:0]       r_credit;   // items in the front pipeline plus queued

    // pointers, fill and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill   <= r_fill + (AW+1)'(i_push) - (AW+1)'(i_pop);
            r_credit <= r_credit + (AW+1)'(i_reserve) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.item  = r_mem[r_rd];
    assign o_room       = (r_credit != FULL_CNT);

    `CTF_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_fill != FULL_CNT, "queue overflow")
    `CTF_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_fill != '0, "queue underflow")
    `CTF_ASSERT_IMP(a_fill_in_credit, i_clk, i_rst_n, 1'b1, r_fill <= r_credit, "fill above credit")
    `CTF_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_credit == '0, !i_push && !i_pop, "traffic with no credit")

endmodule

/* rtl/ctf_back.sv */
module ctf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctf_pkg::t_q_head            i_head,
    input  logic [ctf_pkg::COEF_W-1:0]  i_coef,
    output logic                        o_pop,
    ctf_out_if.source                   o_res
);

    localparam int AW = ctf_pkg::ANG_W;
    localparam int CW = ctf_pkg::ACC_W;
    localparam int MW = 50;

    // filter state, also the payload of the first back stage
    logic                 r_a_valid;
    logic signed [AW-1:0] r_lp;
    logic signed [AW-1:0] r_hp;
    logic        [AW-1:0] r_integ;
    logic signed [AW-1:0] r_a_raw;

    // output stage
    logic                 r_o_valid;
    ctf_pkg::t_res        r_o_data;

    logic                 ready_b;
    logic                 ready_a;

    assign ready_b = !r_o_valid || o_res.ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_pop   = i_head.valid && ready_a;

    // filter update
    logic        [16:0]   ka;
    logic signed [MW-1:0] p_lp;
    logic signed [MW-1:0] p_hp;
    logic signed [CW-1:0] s_lp;
    logic signed [CW-1:0] s_hp;
    logic signed [AW-1:0] n_lp;
    logic signed [AW-1:0] n_hp;
    logic        [AW-1:0] n_integ;

    always_comb begin
        ka      = 17'(18'd65536 - {2'b00, i_coef});
        p_lp    = MW'($signed({1'b0, ka})) * MW'(r_lp);
        p_hp    = MW'($signed({1'b0, ka})) * MW'(r_hp);
        s_lp    = (CW'(p_lp) + CW'(i_head.item.coef_raw) + CW'(32'sd32768)) >>> 16;
        s_hp    = ((CW'(p_hp) + CW'(32'sd32768)) >>> 16) + CW'($signed(i_head.item.inc));
        n_lp    = ctf_pkg::sat_ang(s_lp);
        n_hp    = ctf_pkg::sat_ang(s_hp);
        n_integ = r_integ + i_head.item.inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_lp      <= '0;
            r_hp      <= '0;
            r_integ   <= '0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
                r_lp      <= n_lp;
                r_hp      <= n_hp;
                r_integ   <= n_integ;
            end else if (ready_b) begin
                r_a_valid <= 1'b0;
            end
            if (ready_b) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_raw <= i_head.item.raw_tilt;
        end
        if (ready_b && r_a_valid) begin
            r_o_data.raw_tilt         <= r_a_raw;
            r_o_data.integrated_angle <= r_integ;
            r_o_data.low_passed       <= r_lp;
            r_o_data.high_passed      <= r_hp;
            r_o_data.fused_angle      <= ctf_pkg::sat_ang(CW'(r_lp) + CW'(r_hp));
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_data;

endmodule

/* rtl/complementary_tilt_filter.sv */
// channel   dir  payload                                        transaction
// i_smp     in   accel_y, accel_z, gyro_rate (16 bit signed)    valid & ready
// o_res     out  raw, integrated, low, high, fused (q4.28)      valid & ready
// cfg       in   i_cfg_idx, i_cfg_wdata                         i_cfg_we
//
// one sample per cycle sustained while o_res is not stalled; a result passes through the
// cordic pipeline, one micro-rotation per stage, then the queue and the back end stages
// the filter state update is computed combinationally from its registers in the back end
// reset: synchronous active low, clears state and registers defaults
// a stalled output fills the queue; input ready drops once the items in the cordic
// pipeline plus those queued reach the queue depth
module complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ctf_in_if.sink                            i_smp,
    ctf_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctf_pkg::CFG_DAT_W-1:0]     i_cfg_wdata
);

    localparam int FRONT_LAT = CORDIC_STEPS + 2;
    localparam int Q_AW      = $clog2(FRONT_LAT + 2);

    logic [ctf_pkg::COEF_W-1:0]  r_filter_coef;
    logic [ctf_pkg::SCALE_W-1:0] r_gyro_scale;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_coef <= 16'd1311;
            r_gyro_scale  <= 32'd187236352;
        end else if (i_cfg_we) begin
            case (ctf_pkg::t_cfg_reg'(i_cfg_idx))
                ctf_pkg::REG_FILTER_COEF: r_filter_coef <= i_cfg_wdata[ctf_pkg::COEF_W-1:0];
                ctf_pkg::REG_GYRO_SCALE:  r_gyro_scale  <= i_cfg_wdata[ctf_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    logic              room;
    logic              take;
    logic              push;
    logic              pop;
    ctf_pkg::t_fq_item f_item;
    ctf_pkg::t_q_head  q_head;

    // input transaction accepted while the queue can absorb the pipeline
    assign i_smp.ready = room && i_rst_n;
    assign take        = i_smp.valid && room && i_rst_n;

    ctf_front #(
        .STEPS (CORDIC_STEPS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_smp   (i_smp.data),
        .i_coef  (r_filter_coef),
        .i_scale (r_gyro_scale),
        .o_push  (push),
        .o_item  (f_item)
    );

    ctf_queue #(
        .AW (Q_AW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (take),
        .i_push    (push),
        .i_item    (f_item),
        .i_pop     (pop),
        .o_head    (q_head),
        .o_room    (room)
    );

    ctf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_coef  (r_filter_coef),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
